FILE: rtl/cpm_pkg.sv
package cpm_pkg;

	localparam int CAP_W  = 16;
	localparam int CLK_W  = 25;
	localparam int NUM_W  = 32;
	localparam int DEN_W  = CLK_W + 1;
	localparam int SHF_W  = 4;

	localparam logic [CAP_W-1:0] DUTY_K  = 16'd100;
	localparam logic [CAP_W-1:0] DIST_K  = 16'd34600;
	localparam logic [CAP_W-1:0] SAT_MAX = 16'hFFFF;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_PSC  = 2'd1;
	localparam logic [1:0] REG_CLK  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic [2:0] PSC_NONE = 3'd0;
	localparam logic [2:0] PSC_1    = 3'd1;
	localparam logic [2:0] PSC_8    = 3'd2;
	localparam logic [2:0] PSC_64   = 3'd3;
	localparam logic [2:0] PSC_256  = 3'd4;
	localparam logic [2:0] PSC_1024 = 3'd5;
	localparam logic [2:0] PSC_HI   = 3'd7;

	// dividers are powers of two, so the prescaler becomes a right shift
	function automatic logic [SHF_W-1:0] presc_shift(input logic [2:0] sel);
		logic [SHF_W-1:0] s;
		case (sel) inside
			PSC_NONE, PSC_1: s = 4'd0;
			PSC_8:           s = 4'd3;
			PSC_64:          s = 4'd6;
			PSC_256:         s = 4'd8;
			[PSC_1024:PSC_HI]: s = 4'd10;
			default:         s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/capture_pulse_measurement.sv
// non-completing capture beats: accepted whenever idle, no result
// completing beat, mode 1: one multiply and one divide (distance) before the result
// completing beat, mode 0: one multiply and two divides (duty, then frequency) before the result
// work done by the 16-step serial multiplier and the 32-step serial divider, one item at a time
// s_tready is high again once the result is in the output register
// arst_n clears edge phase, registers to defaults and the output valid
module capture_pulse_measurement
	import cpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // capture_time
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // duty_percent, frequency_hz, distance_cm, status, zero pad
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [24:0] cfg_wdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DIV1 = 3'd2;
	localparam logic [2:0] S_DIV2 = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam logic [1:0] PH_RISE1 = 2'd0;
	localparam logic [1:0] PH_FALL  = 2'd1;
	localparam logic [1:0] PH_RISE2 = 2'd2;

	logic [2:0]       state_q;
	logic [1:0]       phase_q;
	logic             mode_q;
	logic [2:0]       psc_q;
	logic [CLK_W-1:0] clk_hz_q;
	logic [CAP_W-1:0] first_q;
	logic [CAP_W-1:0] second_q;
	logic             op_dist_q;
	logic [DEN_W-1:0] den_q;
	logic [6:0]       r_duty_q;
	logic [CAP_W-1:0] r_freq_q;
	logic [CAP_W-1:0] r_dist_q;
	logic [1:0]       r_status_q;
	logic             m_valid_q;
	logic [47:0]      m_data_q;

	logic             accept;
	logic [SHF_W-1:0] shift;
	logic [DEN_W-1:0] dist_den;
	logic [CLK_W-1:0] freq_num;
	logic [CAP_W-1:0] cap_diff;
	logic [CAP_W-1:0] high_now;
	logic             launch_dist;
	logic             launch_duty;
	logic             mul_start;
	logic [CAP_W-1:0] mul_a;
	logic [CAP_W-1:0] mul_b;
	logic             mul_done;
	logic [NUM_W-1:0] mul_prod;
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic             div_done;
	logic [NUM_W-1:0] div_quot;
	logic             quot_big;
	logic             duty_big;
	logic             out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign shift    = presc_shift(psc_q);
	assign dist_den = DEN_W'({clk_hz_q, 1'b0} >> shift);
	assign freq_num = clk_hz_q >> shift;
	assign cap_diff = s_tdata - first_q;
	assign high_now = second_q - first_q;

	assign launch_dist = accept && (phase_q == PH_FALL) && mode_q;
	assign launch_duty = accept && (phase_q == PH_RISE2);

	assign mul_start = (launch_dist && (dist_den != '0)) || (launch_duty && (cap_diff != '0));
	assign mul_a     = (phase_q == PH_FALL) ? cap_diff : high_now;
	assign mul_b     = (phase_q == PH_FALL) ? DIST_K : DUTY_K;

	assign div_start = ((state_q == S_MUL) && mul_done)
		|| ((state_q == S_DIV1) && div_done && !op_dist_q);
	assign div_num   = (state_q == S_MUL) ? mul_prod : NUM_W'(freq_num);

	assign quot_big = (div_quot[NUM_W-1:CAP_W] != '0);
	assign duty_big = (div_quot > NUM_W'(DUTY_K));

	cpm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	cpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_RISE1;
			mode_q    <= 1'b0;
			psc_q     <= PSC_1;
			clk_hz_q  <= 25'd8000000;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_MODE: begin
						mode_q  <= cfg_wdata[0];
						phase_q <= PH_RISE1;
					end
					REG_PSC: psc_q    <= cfg_wdata[2:0];
					REG_CLK: clk_hz_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (phase_q)
							PH_FALL: begin
								if (mode_q) begin
									phase_q <= PH_RISE1;
									state_q <= (dist_den == '0) ? S_DONE : S_MUL;
								end else begin
									phase_q <= PH_RISE2;
								end
							end
							PH_RISE2: begin
								phase_q <= PH_RISE1;
								state_q <= (cap_diff == '0) ? S_DONE : S_MUL;
							end
							default: phase_q <= PH_FALL;
						endcase
					end
				end
				S_MUL: begin
					if (mul_done)
						state_q <= S_DIV1;
				end
				S_DIV1: begin
					if (div_done)
						state_q <= op_dist_q ? S_DONE : S_DIV2;
				end
				S_DIV2: begin
					if (div_done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				PH_FALL:  second_q <= s_tdata;
				PH_RISE2: ;
				default:  first_q  <= s_tdata;
			endcase
		end
		if (launch_dist || launch_duty) begin
			op_dist_q  <= launch_dist;
			den_q      <= launch_dist ? dist_den : DEN_W'(cap_diff);
			r_duty_q   <= '0;
			r_freq_q   <= '0;
			r_dist_q   <= '0;
			r_status_q <= (launch_dist ? (dist_den == '0) : (cap_diff == '0)) ? ST_ZERO : ST_OK;
		end
		if (div_done && (state_q == S_DIV1)) begin
			if (op_dist_q) begin
				r_dist_q <= quot_big ? SAT_MAX : div_quot[CAP_W-1:0];
				if (quot_big)
					r_status_q <= ST_SAT;
			end else begin
				r_duty_q <= duty_big ? DUTY_K[6:0] : div_quot[6:0];
				if (duty_big)
					r_status_q <= ST_SAT;
			end
		end
		if (div_done && (state_q == S_DIV2)) begin
			r_freq_q <= quot_big ? SAT_MAX : div_quot[CAP_W-1:0];
			if (quot_big)
				r_status_q <= ST_SAT;
		end
		if ((state_q == S_DONE) && out_free)
			m_data_q <= {7'd0, r_status_q, r_dist_q, r_freq_q, r_duty_q};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] <= DUTY_K[6:0]))
		else $error("duty above full scale");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[40:39] == ST_OK || m_tdata[40:39] == ST_ZERO
			|| m_tdata[40:39] == ST_SAT))
		else $error("bad status code");
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[40:39] == ST_ZERO) |-> (m_tdata[38:0] == '0))
		else $error("zero divisor result not cleared");
	a_mode_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[38:23] == '0 || m_tdata[22:0] == '0))
		else $error("distance and duty/frequency both set");
`endif

endmodule

FILE: rtl/cpm_mul.sv
module cpm_mul
	import cpm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CAP_W-1:0] a,
	input  logic [CAP_W-1:0] b,
	output logic             done,
	output logic [NUM_W-1:0] prod
);

	localparam int CNT_W = $clog2(CAP_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CAP_W-1:0] a_q;
	logic [NUM_W-1:0] b_q;
	logic [NUM_W-1:0] acc_q;

	// shift-add, one multiplier bit per cycle, lsb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CAP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= NUM_W'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			if (a_q[0])
				acc_q <= acc_q + b_q;
			a_q <= a_q >> 1;
			b_q <= b_q << 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

FILE: rtl/cpm_div.sv
module cpm_div
	import cpm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;

	// restoring division, one quotient bit per cycle, msb first
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
